### hdl/multilevel_cache_hit_miss_model_defines.svh
// Assertion macros shared by the cache hit/miss model RTL.
`ifndef MULTILEVEL_CACHE_HIT_MISS_MODEL_DEFINES_SVH
`define MULTILEVEL_CACHE_HIT_MISS_MODEL_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define MLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

### hdl/mlc_pkg.sv
// Shared types, constants and helper functions of the cache hit/miss model.
package mlc_pkg;

  localparam int L1_LINES_DEF   = 256;
  localparam int L2_LINES_DEF   = 1024;
  localparam int ADDR_BITS_DEF  = 20;
  localparam int MAX_WAYS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;

  localparam int LOG_W      = 4;
  localparam int L1_AGE_W   = 8;
  localparam int AGE_MAX    = 255;
  localparam int OFFSET_CAP = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int OUT_CNT_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_LOG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_LOG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 3'd4;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_FULL   = 2'd1;

  typedef enum logic [2:0] {
    LV_CLEAR,
    LV_IDLE,
    LV_SCAN,
    LV_UPD,
    LV_DONE
  } lvl_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_L1,
    BK_L2,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    logic ready;
    logic clearing;
    logic done;
    logic hit;
  } lvl_stat_t;

  function automatic int flog2(input int v);
    int k;
    k = 0;
    while (k < 31 && (v >> (k + 1)) != 0) k++;
    return k;
  endfunction

  function automatic int idx_w(input int lines);
    return (lines > 1) ? $clog2(lines) : 1;
  endfunction

endpackage

### hdl/mlc_front.sv
// Front end: configuration registers, input handshake and set/tag classification.
module mlc_front #(
  parameter int L1_LINES  = mlc_pkg::L1_LINES_DEF,
  parameter int L2_LINES  = mlc_pkg::L2_LINES_DEF,
  parameter int ADDR_BITS = mlc_pkg::ADDR_BITS_DEF,
  parameter int MAX_WAYS  = mlc_pkg::MAX_WAYS_DEF,
  localparam int L1_IW = mlc_pkg::idx_w(L1_LINES),
  localparam int L2_IW = mlc_pkg::idx_w(L2_LINES),
  localparam int E_W = 1 + 2 * (mlc_pkg::LOG_W + ADDR_BITS) + L1_IW + L2_IW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mlc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ADDR_BITS-1:0]             address_i,
  input  logic                             clearing_i,
  input  logic                             full_i,
  output logic                             push_o,
  output logic [E_W-1:0]                   entry_o,
  output logic                             clear_o
);

  localparam int LW = mlc_pkg::LOG_W;
  localparam logic [LW-1:0] L1_LOG = LW'(mlc_pkg::flog2(L1_LINES));
  localparam logic [LW-1:0] L2_LOG = LW'(mlc_pkg::flog2(L2_LINES));
  localparam logic [LW-1:0] MW_LOG = LW'(mlc_pkg::flog2(MAX_WAYS));
  localparam logic [LW-1:0] OFF_CAP = LW'(mlc_pkg::OFFSET_CAP);

  logic [1:0]    map_mode_q, ways_q;
  logic [LW-1:0] offset_q, l1log_q, l2log_q;

  logic [LW-1:0] off, l1log, l2log, wl, w1, w2;
  logic [LW-1:0] wlog1, s1, s2;
  logic [ADDR_BITS-1:0] blk, set1, set2, tag1, tag2;
  logic [31:0] base1_w, base2_w;
  logic l2_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q <= 2'd2;
      offset_q   <= LW'(4);
      l1log_q    <= LW'(6);
      l2log_q    <= LW'(8);
      ways_q     <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlc_pkg::CFG_MAP_MODE: map_mode_q <= cfg_data_i[1:0];
        mlc_pkg::CFG_OFFSET:   offset_q   <= cfg_data_i;
        mlc_pkg::CFG_L1_LOG:   l1log_q    <= cfg_data_i;
        mlc_pkg::CFG_L2_LOG:   l2log_q    <= cfg_data_i;
        mlc_pkg::CFG_WAYS:     ways_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Any write to a known register flushes both levels.
  always_comb begin
    case (cfg_idx_i)
      mlc_pkg::CFG_MAP_MODE, mlc_pkg::CFG_OFFSET, mlc_pkg::CFG_L1_LOG,
      mlc_pkg::CFG_L2_LOG, mlc_pkg::CFG_WAYS: clear_o = cfg_we_i;
      default: clear_o = 1'b0;
    endcase
  end

  always_comb begin
    off   = (offset_q > OFF_CAP) ? OFF_CAP : offset_q;
    blk   = address_i >> off;
    l1log = (l1log_q > L1_LOG) ? L1_LOG : l1log_q;
    l2log = (l2log_q > L2_LOG) ? L2_LOG : l2log_q;
    wl    = (LW'(ways_q) > MW_LOG) ? MW_LOG : LW'(ways_q);
    w1    = (wl > l1log) ? l1log : wl;
    w2    = (wl > l2log) ? l2log : wl;
    case (map_mode_q)
      mlc_pkg::MODE_DIRECT: begin
        wlog1 = '0;
        s1    = l1log;
        l2_en = 1'b0;
      end
      mlc_pkg::MODE_FULL: begin
        wlog1 = l1log;
        s1    = '0;
        l2_en = 1'b0;
      end
      default: begin
        wlog1 = w1;
        s1    = l1log - w1;
        l2_en = 1'b1;
      end
    endcase
    s2      = l2log - w2;
    set1    = blk & ADDR_BITS'((32'd1 << s1) - 32'd1);
    set2    = blk & ADDR_BITS'((32'd1 << s2) - 32'd1);
    tag1    = blk >> s1;
    tag2    = blk >> s2;
    base1_w = 32'(set1) << wlog1;
    base2_w = 32'(set2) << w2;
  end

  assign in_ready_o = !full_i && !clearing_i && !cfg_we_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign entry_o    = {l2_en, base1_w[L1_IW-1:0], wlog1, tag1,
                       base2_w[L2_IW-1:0], w2, tag2};

endmodule

### hdl/mlc_fifo.sv
// Two-entry queue between the classifying front end and the lookup back end.
module mlc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

endmodule

### hdl/mlc_level.sv
// One cache level: tag and age memories, way scan, LRU update and flush sweep.
`include "multilevel_cache_hit_miss_model_defines.svh"

module mlc_level #(
  parameter int LINES = 256,
  parameter int AGE_W = 8,
  parameter int TAG_W = 20,
  localparam int IW = mlc_pkg::idx_w(LINES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       start_i,
  input  logic [IW-1:0]              base_i,
  input  logic [mlc_pkg::LOG_W-1:0]  wlog_i,
  input  logic [TAG_W-1:0]           tag_i,
  output mlc_pkg::lvl_stat_t         stat_o
);

  localparam int CW = IW + 1;
  localparam logic [AGE_W-1:0] AGE_SAT =
    (AGE_W >= 8) ? AGE_W'(mlc_pkg::AGE_MAX) : {AGE_W{1'b1}};

  logic [TAG_W:0]   tag_mem [LINES];
  logic [AGE_W-1:0] age_mem [LINES];

  mlc_pkg::lvl_state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, pend_way_q, n_q;
  logic             pend_q;
  logic [IW-1:0]    base_q;
  logic [TAG_W-1:0] tag_q;
  logic [TAG_W:0]   rd_tag_q;
  logic [AGE_W-1:0] rd_age_q;

  logic             hit_found_q, emp_found_q;
  logic [CW-1:0]    hit_way_q, emp_way_q, old_way_q;
  logic [AGE_W-1:0] hit_age_q, old_age_q;

  logic             last_seen, rd_issue;
  logic [IW-1:0]    rd_addr, wr_addr;
  logic             tag_we, age_we;
  logic [TAG_W:0]   tag_wd;
  logic [AGE_W-1:0] age_wd;
  logic [CW-1:0]    tgt_way;
  logic [AGE_W:0]   thresh;

  assign last_seen = pend_q && (pend_way_q == n_q - CW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlc_pkg::LV_CLEAR: if (cnt_q == CW'(LINES - 1)) state_d = mlc_pkg::LV_IDLE;
      mlc_pkg::LV_IDLE:  if (start_i) state_d = mlc_pkg::LV_SCAN;
      mlc_pkg::LV_SCAN:  if (last_seen) state_d = mlc_pkg::LV_UPD;
      mlc_pkg::LV_UPD:   if (last_seen) state_d = mlc_pkg::LV_DONE;
      mlc_pkg::LV_DONE:  state_d = mlc_pkg::LV_IDLE;
      default:           state_d = mlc_pkg::LV_CLEAR;
    endcase
    if (clear_i) state_d = mlc_pkg::LV_CLEAR;
  end

  // Replacement target: the hit way, else the first empty way, else the oldest.
  always_comb begin
    if (hit_found_q) begin
      tgt_way = hit_way_q;
      thresh  = {1'b0, hit_age_q};
    end else if (emp_found_q) begin
      tgt_way = emp_way_q;
      thresh  = {1'b1, {AGE_W{1'b0}}};
    end else begin
      tgt_way = old_way_q;
      thresh  = {1'b0, old_age_q};
    end
  end

  always_comb begin
    rd_issue = ((state_q == mlc_pkg::LV_SCAN) || (state_q == mlc_pkg::LV_UPD))
               && (cnt_q < n_q);
    rd_addr  = base_q + cnt_q[IW-1:0];
    tag_we   = 1'b0;
    age_we   = 1'b0;
    tag_wd   = {1'b1, tag_q};
    age_wd   = '0;
    wr_addr  = base_q + pend_way_q[IW-1:0];
    case (state_q)
      mlc_pkg::LV_CLEAR: begin
        tag_we  = 1'b1;
        tag_wd  = '0;
        wr_addr = cnt_q[IW-1:0];
      end
      mlc_pkg::LV_UPD: begin
        if (pend_q) begin
          if (pend_way_q == tgt_way) begin
            tag_we = 1'b1;
            age_we = 1'b1;
          end else if (rd_tag_q[TAG_W] && ({1'b0, rd_age_q} < thresh)
                       && (rd_age_q < AGE_SAT)) begin
            age_we = 1'b1;
            age_wd = rd_age_q + AGE_W'(1);
          end
        end
      end
      default: ;
    endcase
    stat_o.ready    = (state_q == mlc_pkg::LV_IDLE);
    stat_o.clearing = (state_q == mlc_pkg::LV_CLEAR);
    stat_o.done     = (state_q == mlc_pkg::LV_DONE);
    stat_o.hit      = hit_found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlc_pkg::LV_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_issue;
      if (clear_i || (state_d != state_q)) cnt_q <= '0;
      else if (rd_issue || (state_q == mlc_pkg::LV_CLEAR)) cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_way_q <= cnt_q;
    if ((state_q == mlc_pkg::LV_IDLE) && start_i) begin
      base_q      <= base_i;
      n_q         <= CW'(1) << wlog_i;
      tag_q       <= tag_i;
      hit_found_q <= 1'b0;
      emp_found_q <= 1'b0;
    end else if ((state_q == mlc_pkg::LV_SCAN) && pend_q) begin
      if (rd_tag_q[TAG_W] && (rd_tag_q[TAG_W-1:0] == tag_q) && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_way_q   <= pend_way_q;
        hit_age_q   <= rd_age_q;
      end
      if (!rd_tag_q[TAG_W] && !emp_found_q) begin
        emp_found_q <= 1'b1;
        emp_way_q   <= pend_way_q;
      end
      if ((pend_way_q == '0) || (rd_age_q > old_age_q)) begin
        old_way_q <= pend_way_q;
        old_age_q <= rd_age_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[wr_addr] <= tag_wd;
    if (rd_issue) rd_tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (age_we) age_mem[wr_addr] <= age_wd;
    if (rd_issue) rd_age_q <= age_mem[rd_addr];
  end

  `MLC_ASSERT(a_start_when_idle, start_i |-> (state_q == mlc_pkg::LV_IDLE), "start while busy")
  `MLC_ASSERT(a_no_write_in_scan, (tag_we || age_we) |-> (state_q != mlc_pkg::LV_SCAN), "write during scan")
  `MLC_ASSERT_NEXT(a_done_after_update, (state_q == mlc_pkg::LV_UPD) && last_seen && !clear_i, stat_o.done, "update pass did not finish")

endmodule

### hdl/mlc_back.sv
// Back end: runs the L1 and L2 lookups, keeps the counters and holds the result.
module mlc_back #(
  parameter int L1_LINES   = mlc_pkg::L1_LINES_DEF,
  parameter int L2_LINES   = mlc_pkg::L2_LINES_DEF,
  parameter int ADDR_BITS  = mlc_pkg::ADDR_BITS_DEF,
  parameter int MAX_WAYS   = mlc_pkg::MAX_WAYS_DEF,
  parameter int COUNT_BITS = mlc_pkg::COUNT_BITS_DEF,
  localparam int L1_IW = mlc_pkg::idx_w(L1_LINES),
  localparam int L2_IW = mlc_pkg::idx_w(L2_LINES),
  localparam int E_W = 1 + 2 * (mlc_pkg::LOG_W + ADDR_BITS) + L1_IW + L2_IW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          q_valid_i,
  input  logic [E_W-1:0]                q_entry_i,
  output logic                          q_pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          l1_hit_o,
  output logic                          l2_looked_up_o,
  output logic                          l2_hit_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0] l1_hit_total_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0] l1_miss_total_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0] l2_hit_total_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0] l2_miss_total_o
);

  localparam int LW = mlc_pkg::LOG_W;
  localparam int L2_AGE_W = mlc_pkg::idx_w(MAX_WAYS);

  logic                 e_l2_en;
  logic [L1_IW-1:0]     e_b1;
  logic [LW-1:0]        e_w1, e_w2;
  logic [ADDR_BITS-1:0] e_t1, e_t2;
  logic [L2_IW-1:0]     e_b2;

  logic                 l2_en_q;
  logic [L2_IW-1:0]     b2_q;
  logic [LW-1:0]        w2_q;
  logic [ADDR_BITS-1:0] t2_q;

  mlc_pkg::back_state_e state_q, state_d;
  mlc_pkg::lvl_stat_t   l1_stat, l2_stat;
  logic start_l1, start_l2, load_out;
  logic l1_hit_q, looked_q, l2_hit_q;
  logic [COUNT_BITS-1:0] c_l1h_q, c_l1m_q, c_l2h_q, c_l2m_q;
  logic out_valid_q;

  assign {e_l2_en, e_b1, e_w1, e_t1, e_b2, e_w2, e_t2} = q_entry_i;

  mlc_level #(
    .LINES (L1_LINES),
    .AGE_W (mlc_pkg::L1_AGE_W),
    .TAG_W (ADDR_BITS)
  ) u_l1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear_i),
    .start_i (start_l1),
    .base_i  (e_b1),
    .wlog_i  (e_w1),
    .tag_i   (e_t1),
    .stat_o  (l1_stat)
  );

  mlc_level #(
    .LINES (L2_LINES),
    .AGE_W (L2_AGE_W),
    .TAG_W (ADDR_BITS)
  ) u_l2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear_i),
    .start_i (start_l2),
    .base_i  (b2_q),
    .wlog_i  (w2_q),
    .tag_i   (t2_q),
    .stat_o  (l2_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlc_pkg::BK_IDLE: if (q_valid_i && l1_stat.ready && l2_stat.ready)
                          state_d = mlc_pkg::BK_L1;
      mlc_pkg::BK_L1: begin
        if (l1_stat.done) begin
          state_d = (l2_en_q && !l1_stat.hit) ? mlc_pkg::BK_L2 : mlc_pkg::BK_FIN;
        end
      end
      mlc_pkg::BK_L2:   if (l2_stat.done) state_d = mlc_pkg::BK_FIN;
      mlc_pkg::BK_FIN:  if (!out_valid_q || out_ready_i) state_d = mlc_pkg::BK_IDLE;
      default:          state_d = mlc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    start_l1 = (state_q == mlc_pkg::BK_IDLE) && q_valid_i && l1_stat.ready && l2_stat.ready;
    start_l2 = (state_q == mlc_pkg::BK_L1) && l1_stat.done && l2_en_q && !l1_stat.hit;
    load_out = (state_q == mlc_pkg::BK_FIN) && (!out_valid_q || out_ready_i);
    q_pop_o  = start_l1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlc_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      c_l1h_q     <= '0;
      c_l1m_q     <= '0;
      c_l2h_q     <= '0;
      c_l2m_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (load_out) begin
        if (l1_hit_q) begin
          if (c_l1h_q != '1) c_l1h_q <= c_l1h_q + COUNT_BITS'(1);
        end else if (c_l1m_q != '1) begin
          c_l1m_q <= c_l1m_q + COUNT_BITS'(1);
        end
        if (looked_q && l2_hit_q && (c_l2h_q != '1)) c_l2h_q <= c_l2h_q + COUNT_BITS'(1);
        if (looked_q && !l2_hit_q && (c_l2m_q != '1)) c_l2m_q <= c_l2m_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_l1) begin
      l2_en_q  <= e_l2_en;
      b2_q     <= e_b2;
      w2_q     <= e_w2;
      t2_q     <= e_t2;
      looked_q <= 1'b0;
      l2_hit_q <= 1'b0;
    end
    if ((state_q == mlc_pkg::BK_L1) && l1_stat.done) l1_hit_q <= l1_stat.hit;
    if ((state_q == mlc_pkg::BK_L2) && l2_stat.done) begin
      looked_q <= 1'b1;
      l2_hit_q <= l2_stat.hit;
    end
    if (load_out) begin
      l1_hit_o       <= l1_hit_q;
      l2_looked_up_o <= looked_q;
      l2_hit_o       <= l2_hit_q;
    end
  end

  // Totals are shown from the live counters, which only move when a result loads.
  assign l1_hit_total_o  = mlc_pkg::OUT_CNT_W'(c_l1h_q);
  assign l1_miss_total_o = mlc_pkg::OUT_CNT_W'(c_l1m_q);
  assign l2_hit_total_o  = mlc_pkg::OUT_CNT_W'(c_l2h_q);
  assign l2_miss_total_o = mlc_pkg::OUT_CNT_W'(c_l2m_q);
  assign out_valid_o     = out_valid_q;
  assign clearing_o      = l1_stat.clearing || l2_stat.clearing;

endmodule

### hdl/multilevel_cache_hit_miss_model.sv
// Each level scans its set once to find hit, empty and oldest way, then sweeps it again for ages.
// Lookups run for one item at a time; the next item is classified and queued meanwhile.
// After reset and after every write to a known register, a flush sweep runs before input.
// Reset is asynchronous and active low; registers return to 2, 4, 6, 8, 2 and counters to zero.
module multilevel_cache_hit_miss_model #(
  parameter int L1_LINES   = mlc_pkg::L1_LINES_DEF,
  parameter int L2_LINES   = mlc_pkg::L2_LINES_DEF,
  parameter int ADDR_BITS  = mlc_pkg::ADDR_BITS_DEF,
  parameter int MAX_WAYS   = mlc_pkg::MAX_WAYS_DEF,
  parameter int COUNT_BITS = mlc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mlc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ADDR_BITS-1:0]           address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           l1_hit_o,
  output logic                           l2_looked_up_o,
  output logic                           l2_hit_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0]  l1_hit_total_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0]  l1_miss_total_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0]  l2_hit_total_o,
  output logic [mlc_pkg::OUT_CNT_W-1:0]  l2_miss_total_o
);

  localparam int L1_IW = mlc_pkg::idx_w(L1_LINES);
  localparam int L2_IW = mlc_pkg::idx_w(L2_LINES);
  localparam int E_W = 1 + 2 * (mlc_pkg::LOG_W + ADDR_BITS) + L1_IW + L2_IW;

  // The front end turns each address into an L1 and an L2 set base, log2 way count and tag.
  logic           push, full, pop, q_valid, clear, clearing;
  logic [E_W-1:0] push_entry, head_entry;

  mlc_front #(
    .L1_LINES  (L1_LINES),
    .L2_LINES  (L2_LINES),
    .ADDR_BITS (ADDR_BITS),
    .MAX_WAYS  (MAX_WAYS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .address_i  (address_i),
    .clearing_i (clearing),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry),
    .clear_o    (clear)
  );

  // A two-item queue lets the front keep accepting while the back is busy.
  mlc_fifo #(
    .WIDTH (E_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  // The back end runs the lookups and holds the finished result in an output register.
  mlc_back #(
    .L1_LINES   (L1_LINES),
    .L2_LINES   (L2_LINES),
    .ADDR_BITS  (ADDR_BITS),
    .MAX_WAYS   (MAX_WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_i         (clear),
    .q_valid_i       (q_valid),
    .q_entry_i       (head_entry),
    .q_pop_o         (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .l1_hit_o        (l1_hit_o),
    .l2_looked_up_o  (l2_looked_up_o),
    .l2_hit_o        (l2_hit_o),
    .l1_hit_total_o  (l1_hit_total_o),
    .l1_miss_total_o (l1_miss_total_o),
    .l2_hit_total_o  (l2_hit_total_o),
    .l2_miss_total_o (l2_miss_total_o)
  );

endmodule

### tb/tb_multilevel_cache_hit_miss_model.sv
// Self-checking testbench of the two-level cache hit/miss model.
module tb_multilevel_cache_hit_miss_model;
  import mlc_pkg::*;

  localparam logic [1:0] MODE_TWO_LEVEL = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  // Longest lookup is a 256-line fully associative scan, with margin.
  localparam int SETTLE_CYCLES = 800;
  localparam int N_RANDOM_PHASES = 14;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [19:0] address_i;
  logic out_valid_o, out_ready_i;
  logic l1_hit_o, l2_looked_up_o, l2_hit_o;
  logic [31:0] l1_hit_total_o, l1_miss_total_o, l2_hit_total_o, l2_miss_total_o;

  multilevel_cache_hit_miss_model DUT (.*);

  // One classified lookup as the block reports it.
  typedef struct packed {
    logic l1_hit;
    logic looked;
    logic l2_hit;
    logic [31:0] l1_hits;
    logic [31:0] l1_misses;
    logic [31:0] l2_hits;
    logic [31:0] l2_misses;
  } lookup_t;

  // A row of the directed table: either a register write or an address. Where
  // typed is set, the hit flags are given by hand and override the prediction.
  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [19:0] addr;
    bit typed;
    bit e_l1, e_look, e_l2;
  } row_t;

  // Shadow of the block's tag stores; index 0 is L1 and index 1 is L2.
  logic [19:0] shadow_tag [2][1024];
  bit          shadow_vld [2][1024];
  bit   [7:0]  shadow_age [2][1024];
  longint unsigned hit_miss [4];
  logic [1:0] m_mode;
  logic [3:0] m_off, m_l1log, m_l2log;
  logic [1:0] m_ways;

  lookup_t pending_lookups [$];
  bit typed_pending;
  bit typed_l1, typed_look, typed_l2;
  int mismatches, items_sent, phases_run, l1_hits_seen, l2_lookups_seen;
  bit quiet;
  int ready_stall;

  // Clock and the single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int clip(input int v, input int lim);
    return v > lim ? lim : v;
  endfunction

  function automatic void flush_shadow();
    for (int lv = 0; lv < 2; lv++)
      for (int i = 0; i < 1024; i++) begin
        shadow_vld[lv][i] = 1'b0;
        shadow_age[lv][i] = 8'd0;
      end
  endfunction

  function automatic void count_up(input int which);
    if (hit_miss[which] < 64'hFFFF_FFFF) hit_miss[which]++;
  endfunction

  // Make way h the youngest of its set; younger valid ways age by one.
  function automatic void promote(input int lv, input int base, input int n, input int h);
    bit [7:0] a;
    a = shadow_age[lv][base + h];
    for (int w = 0; w < n; w++)
      if (shadow_vld[lv][base + w] && shadow_age[lv][base + w] < a &&
          shadow_age[lv][base + w] < AGE_MAX)
        shadow_age[lv][base + w]++;
    shadow_age[lv][base + h] = 8'd0;
  endfunction

  // Probe one set; a miss fills the lowest empty way, else the oldest one.
  function automatic bit probe_set(input int lv, input int base, input int n,
                                   input logic [19:0] tag);
    int victim;
    bit empty_found;
    victim = 0;
    empty_found = 1'b0;
    for (int w = 0; w < n; w++)
      if (shadow_vld[lv][base + w] && shadow_tag[lv][base + w] == tag) begin
        promote(lv, base, n, w);
        return 1'b1;
      end
    for (int w = 0; w < n; w++)
      if (!empty_found && !shadow_vld[lv][base + w]) begin
        victim = w;
        empty_found = 1'b1;
      end
    if (empty_found) begin
      for (int w = 0; w < n; w++)
        if (shadow_vld[lv][base + w] && shadow_age[lv][base + w] < AGE_MAX)
          shadow_age[lv][base + w]++;
      shadow_age[lv][base + victim] = 8'd0;
    end else begin
      for (int w = 1; w < n; w++)
        if (shadow_age[lv][base + w] > shadow_age[lv][base + victim]) victim = w;
      promote(lv, base, n, victim);
    end
    shadow_vld[lv][base + victim] = 1'b1;
    shadow_tag[lv][base + victim] = tag;
    return 1'b0;
  endfunction

  // Classify one address and advance the shadow stores and counters.
  function automatic lookup_t classify(input logic [19:0] addr);
    lookup_t r;
    int off, l1log, l2log, wl, w1, w2, s1, s2;
    logic [19:0] blk;
    bit h1, h2, looked;
    off = clip(m_off, OFFSET_CAP);
    blk = addr >> off;
    l1log = clip(m_l1log, 8);
    h2 = 1'b0;
    looked = 1'b0;
    if (m_mode == MODE_DIRECT) begin
      h1 = probe_set(0, blk & ((1 << l1log) - 1), 1, blk >> l1log);
    end else if (m_mode == MODE_FULL) begin
      h1 = probe_set(0, 0, 1 << l1log, blk);
    end else begin
      // Two-level mode; the spare mode code lands here as well.
      l2log = clip(m_l2log, 10);
      wl = clip(m_ways, 3);
      w1 = clip(wl, l1log);
      w2 = clip(wl, l2log);
      s1 = l1log - w1;
      s2 = l2log - w2;
      h1 = probe_set(0, (blk & ((1 << s1) - 1)) << w1, 1 << w1, blk >> s1);
      if (!h1) begin
        looked = 1'b1;
        h2 = probe_set(1, (blk & ((1 << s2) - 1)) << w2, 1 << w2, blk >> s2);
        count_up(h2 ? 2 : 3);
      end
    end
    count_up(h1 ? 0 : 1);
    r.l1_hit = h1;
    r.looked = looked;
    r.l2_hit = h2;
    r.l1_hits = hit_miss[0][31:0];
    r.l1_misses = hit_miss[1][31:0];
    r.l2_hits = hit_miss[2][31:0];
    r.l2_misses = hit_miss[3][31:0];
    return r;
  endfunction

  // Everything at the rising edge: register writes, accepted addresses and
  // results are all seen here, so the shadow follows the block edge by edge.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want, got;
    if (!rst_ni) begin
      flush_shadow();
      for (int i = 0; i < 4; i++) hit_miss[i] = 0;
      m_mode = MODE_TWO_LEVEL;
      m_off = 4'd4;
      m_l1log = 4'd6;
      m_l2log = 4'd8;
      m_ways = 2'd2;
      pending_lookups.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{l1_hit_o, l2_looked_up_o, l2_hit_o, l1_hit_total_o,
                l1_miss_total_o, l2_hit_total_o, l2_miss_total_o};
        if (pending_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          want = pending_lookups[0];
          pending_lookups.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
          if (got.l1_hit) l1_hits_seen++;
          if (got.looked) l2_lookups_seen++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAP_MODE: begin m_mode = cfg_data_i[1:0]; flush_shadow(); end
          CFG_OFFSET:   begin m_off = cfg_data_i; flush_shadow(); end
          CFG_L1_LOG:   begin m_l1log = cfg_data_i; flush_shadow(); end
          CFG_L2_LOG:   begin m_l2log = cfg_data_i; flush_shadow(); end
          CFG_WAYS:     begin m_ways = cfg_data_i[1:0]; flush_shadow(); end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        want = classify(address_i);
        if (typed_pending) begin
          want.l1_hit = typed_l1;
          want.looked = typed_look;
          want.l2_hit = typed_l2;
        end
        pending_lookups = {pending_lookups, want};
        items_sent++;
      end
    end
  end

  // Result side: ready drops in random bursts until the quiet tail of the run.
  initial begin
    out_ready_i = 1'b0;
    ready_stall = 0;
    forever begin
      @(negedge clk_i);
      if (ready_stall > 0) begin
        out_ready_i <= 1'b0;
        ready_stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) ready_stall = $urandom_range(1, 11);
      end
    end
  end

  // Present one address and hold it until taken; maybe idle afterwards.
  task automatic send_address(input logic [19:0] addr);
    in_valid_i <= 1'b1;
    address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    typed_pending = 1'b0;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  // Registers are only written once every lookup has come back and the
  // block has had time to finish anything in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] data);
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic [3:0] off,
                           input logic [3:0] l1log, input logic [3:0] l2log,
                           input logic [1:0] ways, input int n_items);
    logic [19:0] hot [16];
    logic [19:0] a;
    write_reg(CFG_MAP_MODE, {2'b00, mode});
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_L1_LOG, l1log);
    write_reg(CFG_L2_LOG, l2log);
    write_reg(CFG_WAYS, {2'b00, ways});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_NO_REG, 4'($urandom()));
    phases_run++;
    // A small working set makes hits, refills and evictions all common.
    for (int i = 0; i < 16; i++) hot[i] = 20'($urandom());
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        a = hot[$urandom_range(0, 15)] ^ 20'($urandom_range(0, 255));
      end else begin
        a = 20'($urandom());
      end
      send_address(a);
    end
  endtask

  row_t directed [] = '{
    // Reset setting: two-level mode, 16-byte lines.
    '{0, CFG_MAP_MODE, 4'd0, 20'h00000, 1, 0, 1, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h00000, 1, 1, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'hFFFFF, 1, 0, 1, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h0000F, 1, 1, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'hFFFF0, 0, 0, 0, 0},
    // Direct mapped; the write flushes both levels.
    '{1, CFG_MAP_MODE, 4'd0, 20'h00000, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h00000, 1, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h00000, 1, 1, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h00400, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h00000, 0, 0, 0, 0},
    // Offset beyond the cap counts as 256-byte lines.
    '{1, CFG_OFFSET, 4'd15, 20'h00000, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h00100, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h001FF, 0, 0, 0, 0},
    // The spare mode code acts as the two-level mode.
    '{1, CFG_MAP_MODE, 4'd3, 20'h00000, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h12345, 1, 0, 1, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h12345, 1, 1, 0, 0},
    // A write to an index past the list changes nothing and keeps lines.
    '{1, CFG_NO_REG, 4'd15, 20'h00000, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h12345, 1, 1, 0, 0},
    // Oversized line counts and ways are clipped to what the stores hold.
    '{1, CFG_L1_LOG, 4'd15, 20'h00000, 0, 0, 0, 0},
    '{1, CFG_L2_LOG, 4'd15, 20'h00000, 0, 0, 0, 0},
    '{1, CFG_WAYS, 4'd3, 20'h00000, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'hABCDE, 0, 0, 0, 0},
    // Fully associative with a single line.
    '{1, CFG_MAP_MODE, 4'd1, 20'h00000, 0, 0, 0, 0},
    '{1, CFG_L1_LOG, 4'd0, 20'h00000, 0, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'h55555, 1, 0, 0, 0},
    '{0, CFG_MAP_MODE, 4'd0, 20'hAAAAA, 1, 0, 0, 0}
  };

  initial begin
    logic [1:0] mode;
    logic [3:0] l1log;
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    address_i = '0;
    quiet = 1'b0;
    typed_pending = 1'b0;
    mismatches = 0;
    items_sent = 0;
    phases_run = 0;
    l1_hits_seen = 0;
    l2_lookups_seen = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        typed_pending = directed[i].typed;
        typed_l1 = directed[i].e_l1;
        typed_look = directed[i].e_look;
        typed_l2 = directed[i].e_l2;
        send_address(directed[i].addr);
      end
    end

    // Extreme settings first, then random ones. Large fully associative
    // scans are slow, so those phases stay short.
    run_phase(MODE_DIRECT, 4'd0, 4'd0, 4'd0, 2'd0, 60);
    run_phase(MODE_DIRECT, 4'd8, 4'd8, 4'd10, 2'd3, 150);
    run_phase(MODE_FULL, 4'd4, 4'd8, 4'd10, 2'd3, 25);
    run_phase(MODE_TWO_LEVEL, 4'd8, 4'd8, 4'd10, 2'd3, 150);
    run_phase(MODE_TWO_LEVEL, 4'd0, 4'd0, 4'd0, 2'd0, 80);
    run_phase(MODE_SPARE, 4'd15, 4'd15, 4'd15, 2'd3, 120);
    for (int p = 0; p < N_RANDOM_PHASES; p++) begin
      mode = 2'($urandom_range(0, 3));
      l1log = 4'($urandom_range(0, 15));
      n = (mode == MODE_FULL && l1log > 5) ? 25 : 110;
      if (p == N_RANDOM_PHASES - 1) quiet = 1'b1;
      run_phase(mode, 4'($urandom_range(0, 15)), l1log, 4'($urandom_range(0, 15)),
                2'($urandom_range(0, 3)), n);
    end

    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d addresses over %0d register settings in all map modes.",
             items_sent, phases_run);
    $display("Saw %0d L1 hits and %0d L2 lookups; %0d mismatching results.",
             l1_hits_seen, l2_lookups_seen, mismatches);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mlc_pkg.sv
hdl/mlc_front.sv
hdl/mlc_fifo.sv
hdl/mlc_level.sv
hdl/mlc_back.sv
hdl/multilevel_cache_hit_miss_model.sv
tb/tb_multilevel_cache_hit_miss_model.sv
